/* src/sita_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the signed integer to decimal ASCII block.
// Used by the controller, the datapath and the top level.
package sita_pkg;

  localparam logic [5:0] CHAR_MINUS = 6'd45;
  localparam logic [5:0] CHAR_ZERO  = 6'd48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_TRIM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic trim_step;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic neg;
    logic top_zero;
    logic dig_last;
    logic out_free;
  } sts_t;

  // decimal digits of 2^(bits-1), the largest magnitude
  function automatic int calc_digits(int bits);
    longint unsigned v;
    int d;
    v = 64'd1 << (bits - 1);
    d = 0;
    do begin
      v = v / 10;
      d++;
    end while (v != 0);
    return d;
  endfunction

endpackage

/* src/signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// Top level of the signed integer to decimal ASCII converter.
// Instantiates sita_ctrl and sita_dp; types come from sita_pkg.
//
// Each accepted value leaves as its decimal text, one ASCII character per
// out beat, minus sign first for negatives, no leading zeros, out_last on
// the final digit. The magnitude is turned into BCD by a shift-add-3 loop
// that takes one magnitude bit per cycle. A number passes through these
// steps in order: accept, convert all VALUE_BITS bits, emit the minus sign
// if negative, drop the leading zero digits, then send the digits. Stalls
// on out_ready hold the sign and digit sends. in_ready is high only between
// numbers.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [5:0]                   out_character,
  output logic                         out_last
);

  sita_pkg::cmd_t cmd;
  sita_pkg::sts_t sts;

  sita_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sita_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

/* src/sita_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine for the decimal ASCII converter.
// Depends on sita_pkg for the state, command and status types.
module sita_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sita_pkg::sts_t  sts,
  output sita_pkg::cmd_t  cmd
);

  sita_pkg::state_t state_r;
  sita_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sita_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      sita_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sita_pkg::ST_CONV;
        end
      end
      sita_pkg::ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) begin
          state_nxt = sts.neg ? sita_pkg::ST_SIGN : sita_pkg::ST_TRIM;
        end
      end
      sita_pkg::ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = sita_pkg::ST_TRIM;
        end
      end
      sita_pkg::ST_TRIM: begin
        if (sts.top_zero && !sts.dig_last) begin
          cmd.trim_step = 1'b1;
        end else begin
          state_nxt = sita_pkg::ST_EMIT;
        end
      end
      sita_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.dig_last) begin
            state_nxt = sita_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sita_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* src/sita_dp.sv */
`timescale 1ns / 1ps
// Datapath: magnitude shifter, shift-add-3 BCD register and output register.
// Depends on sita_pkg for command and status types and character codes.
module sita_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  sita_pkg::cmd_t               cmd,
  output sita_pkg::sts_t               sts,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [5:0]                   out_character,
  output logic                         out_last
);

  localparam int Digits = sita_pkg::calc_digits(VALUE_BITS);
  localparam int BcdW   = 4 * Digits;
  localparam int CntW   = $clog2(VALUE_BITS + 1);
  localparam int DigW   = $clog2(Digits + 1);

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [BcdW-1:0]       bcd_r, bcd_nxt;
  logic [CntW-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [DigW-1:0]       dig_cnt_r, dig_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [5:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0] magnitude;
  logic [BcdW-1:0]       adj;
  logic [3:0]            top_digit;

  assign magnitude = in_value[VALUE_BITS-1]
                   ? (~$unsigned(in_value) + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                   : $unsigned(in_value);
  assign top_digit = bcd_r[BcdW-1 -: 4];

  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
    end
  end

  assign sts.conv_last = (bit_cnt_r == CntW'(1));
  assign sts.neg       = neg_r;
  assign sts.top_zero  = (top_digit == 4'd0);
  assign sts.dig_last  = (dig_cnt_r == DigW'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    priority if (cmd.load) begin
      mag_nxt     = magnitude;
      neg_nxt     = in_value[VALUE_BITS-1];
      bcd_nxt     = '0;
      bit_cnt_nxt = CntW'(VALUE_BITS);
      dig_cnt_nxt = DigW'(Digits);
    end else if (cmd.conv_step) begin
      bcd_nxt     = {adj[BcdW-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - CntW'(1);
    end else if (cmd.trim_step) begin
      bcd_nxt     = {bcd_r[BcdW-5:0], 4'd0};
      dig_cnt_nxt = dig_cnt_r - DigW'(1);
    end else if (cmd.emit_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = sita_pkg::CHAR_MINUS;
      out_last_nxt  = 1'b0;
    end else if (cmd.emit_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = sita_pkg::CHAR_ZERO + {2'b00, top_digit};
      out_last_nxt  = sts.dig_last;
      bcd_nxt       = {bcd_r[BcdW-5:0], 4'd0};
      dig_cnt_nxt   = dig_cnt_r - DigW'(1);
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bcd_r      <= bcd_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

/* bench/signed_int_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for signed_int_to_decimal_ascii: predicts the ASCII digit
// stream for each accepted value and checks every out beat against it.
// Depends on sita_pkg and the signed_int_to_decimal_ascii top level in src.
module signed_int_to_decimal_ascii_tb;

  localparam int VALUE_BITS = 32;
  localparam int RANDOM_PER_PHASE = 83;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [5:0] ch;
    logic       last;
  } text_beat_t;

  class digit_scoreboard;
    text_beat_t pending_q[$];
    int mismatches;
    int numbers;
    int negatives;
    int chars_checked;

    function new();
      mismatches = 0;
      numbers = 0;
      negatives = 0;
      chars_checked = 0;
    endfunction

    // expand one accepted value into its expected character beats
    function void note_value(logic signed [VALUE_BITS-1:0] v);
      logic [VALUE_BITS-1:0] mag;
      logic [3:0] dig [0:19];
      int nd;
      text_beat_t b;
      mag = v;
      nd = 0;
      if (v[VALUE_BITS-1]) begin
        mag = ~mag + 1'b1;
        b.ch = sita_pkg::CHAR_MINUS;
        b.last = 1'b0;
        pending_q.push_back(b);
        negatives++;
      end
      do begin
        dig[nd] = 4'(mag % 10);
        mag = mag / 10;
        nd++;
      end while (mag != 0);
      for (int i = nd - 1; i >= 0; i--) begin
        b.ch = sita_pkg::CHAR_ZERO + 6'(dig[i]);
        b.last = (i == 0);
        pending_q.push_back(b);
      end
      numbers++;
    endfunction

    function void check_char(logic [5:0] ch, logic last);
      text_beat_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual char %0d last %0b",
                 $time, ch, last);
        return;
      end
      e = pending_q.pop_front();
      chars_checked++;
      if (ch !== e.ch) begin
        mismatches++;
        $display("%0t: character mismatch, expected %0d, actual %0d", $time, e.ch, ch);
      end
      if (last !== e.last) begin
        mismatches++;
        $display("%0t: last mismatch, expected %0b, actual %0b", $time, e.last, last);
      end
    endfunction

    function void flag_leftover();
      if (pending_q.size() != 0) begin
        mismatches += pending_q.size();
        $display("%0t: %0d expected beats never arrived, expected %0d, actual 0",
                 $time, pending_q.size(), pending_q.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [VALUE_BITS-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_character;
  logic out_last;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_toggle = 1'b0;
  digit_scoreboard sb;

  signed_int_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_character(out_character),
    .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial sb = new();

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_value(in_value);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_char(out_character, out_last);
  end

  // receiver: random back-pressure, plus a long hold on request
  initial begin
    int hold_left;
    logic seen_toggle;
    hold_left = 0;
    seen_toggle = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen_toggle) begin
        seen_toggle = hold_toggle;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic offer_value(input logic signed [VALUE_BITS-1:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // pick a digit count first so short and long numbers both show up
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    int nd;
    longint lo;
    longint hi;
    longint mag;
    logic neg;
    if ($urandom_range(3) == 0) return $urandom;
    nd = $urandom_range(1, 10);
    neg = 1'($urandom_range(1));
    lo = 1;
    repeat (nd - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (nd == 1) lo = 0;
    if (hi > 64'sd2147483647) hi = neg ? 64'sd2147483648 : 64'sd2147483647;
    mag = lo + (longint'($urandom) % (hi - lo + 1));
    mag = neg ? -mag : mag;
    return mag[VALUE_BITS-1:0];
  endfunction

  task automatic run_random(input int count);
    repeat (count) offer_value(pick_value());
  endtask

  initial begin
    logic signed [VALUE_BITS-1:0] directed_q[$];
    int wait_cycles;
    directed_q = '{0, 1, -1, 7, -7, 9, 10, -10, 42, 99, 100, -100,
                   999999999, -999999999, 1000000000, 1234567890, -1234567890,
                   32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFF, 32'h80000000, 32'h80000001};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[i]) offer_value(directed_q[i]);

    tx_idle_pct = 6;
    rx_idle_pct = 68;
    run_random(RANDOM_PER_PHASE);

    tx_idle_pct = 68;
    rx_idle_pct = 6;
    run_random(RANDOM_PER_PHASE);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_toggle <= ~hold_toggle;
    run_random(RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    wait_cycles = 60;
    repeat (wait_cycles) @(posedge clk);
    sb.flag_leftover();

    $display("Converted %0d values (%0d negative) into %0d checked characters,",
             sb.numbers, sb.negatives, sb.chars_checked);
    $display("over directed extremes, three pacing mixes and one long output hold.");
    if (sb.mismatches == 0) begin
      $display("** signed_int_to_decimal_ascii: PASSED **");
    end else begin
      $display("** signed_int_to_decimal_ascii: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out waiting for the block to finish.");
    $display("** signed_int_to_decimal_ascii: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
src/sita_pkg.sv
src/sita_ctrl.sv
src/sita_dp.sv
src/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_tb.sv
